// ===== hw/rtl/cctdl_pkg.sv =====
// shared types, constants and coefficients of the daylight-locus chromaticity unit
package cctdl_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int X_WORK_BITS   = 28;
    localparam int TEMP_W        = 16;
    localparam int CHROMA_W      = 16;
    localparam int WIDE_W        = 64;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_LOW  = 2'd1,
        STATUS_HIGH = 2'd2
    } status_t;

    localparam logic [TEMP_W-1:0] T_LOW  = 16'd4000;
    localparam logic [TEMP_W-1:0] T_MID  = 16'd7000;
    localparam logic [TEMP_W-1:0] T_HIGH = 16'd25000;

    // coefficient set for 4000..6999 K
    localparam logic [52:0] COEF_C_A  = 53'd4607000000000000;
    localparam logic [41:0] COEF_K2_A = 42'd2967800000000;
    localparam logic [27:0] COEF_K1_A = 28'd99110000;
    localparam logic [17:0] COEF_K0_A = 18'd244063;

    // coefficient set for 7000..24999 K
    localparam logic [52:0] COEF_C_B  = 53'd2006400000000000;
    localparam logic [41:0] COEF_K2_B = 42'd1901800000000;
    localparam logic [27:0] COEF_K1_B = 28'd247480000;
    localparam logic [17:0] COEF_K0_B = 18'd237040;

    localparam logic [19:0] DEN_SCALE = 20'd1000000;

    localparam logic [8:0]        Y_X_MUL       = 9'd300;
    localparam logic [37:0]       Y_LIN         = 38'd287 << X_WORK_BITS;
    localparam int                Y_OFF_EXP     = 55;
    localparam logic [WIDE_W-1:0] Y_OFF         = 64'd55 << Y_OFF_EXP;
    localparam logic [WIDE_W-1:0] Y_BIAS        = 64'd100;
    localparam logic [WIDE_W-1:0] Y_SAT_LIMIT   = 64'd13107200;
    localparam logic [21:0]       Y_RECIP       = 22'd2684355;
    localparam int                Y_RECIP_SHIFT = 26;

    localparam logic [CHROMA_W-1:0] CHROMA_MAX = 16'hFFFF;

    typedef struct packed {
        logic [WIDE_W-1:0] num;
        logic [WIDE_W-1:0] den;
        status_t           status;
    } cctdl_frac_t;

    function automatic int quot_bits(input int frac_bits);
        quot_bits = ((frac_bits > X_WORK_BITS) ? frac_bits : X_WORK_BITS) + 1;
    endfunction

endpackage

// ===== hw/rtl/cctdl_poly.sv =====
// range check and six-stage polynomial numerator and denominator pipeline
module cctdl_poly
    import cctdl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [TEMP_W-1:0] temperature_kelvin,
    output logic              out_valid,
    input  logic              out_ready,
    output cctdl_frac_t       frac
);

    localparam int STAGES = 6;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES:0]   adv;

    logic [TEMP_W-1:0] t1_reg, t2_reg, t3_reg;
    logic              sel1_reg, sel2_reg, sel3_reg, sel4_reg;
    status_t           st1_reg, st2_reg, st3_reg, st4_reg, st5_reg, st6_reg;
    status_t           st1_next;

    logic [34:0]       s1_reg, s1_next;
    logic [35:0]       d1_reg, d1_next;
    logic [51:0]       s2_reg, s2_next;
    logic [51:0]       d2_reg, d2_next;
    logic [WIDE_W-1:0] n3_reg, n3_next, d3_reg, d3_next;
    logic [WIDE_W-1:0] n4_reg, n4_next, d4_reg;
    logic [WIDE_W-1:0] num6_reg, num6_next, den6_reg;

    logic [17:0] k0_sel;
    logic [27:0] k1_sel;
    logic [41:0] k2_sel;
    logic [52:0] c_sel;
    logic [33:0] prod_k0;
    logic [50:0] prod_s1;
    logic [67:0] prod_s2;
    logic [67:0] prod_d2;

    assign adv[STAGES] = out_ready;
    for (genvar i = 0; i < STAGES; i++)
    begin : g_adv
        assign adv[i] = !vld_reg[i] || adv[i+1];
    end
    assign in_ready  = adv[0];
    assign out_valid = vld_reg[STAGES-1];

    always_comb
    begin
        priority if (temperature_kelvin < T_LOW)
        begin
            st1_next = STATUS_LOW;
        end
        else if (temperature_kelvin >= T_HIGH)
        begin
            st1_next = STATUS_HIGH;
        end
        else
        begin
            st1_next = STATUS_OK;
        end
    end

    assign k0_sel  = sel1_reg ? COEF_K0_B : COEF_K0_A;
    assign k1_sel  = sel1_reg ? COEF_K1_B : COEF_K1_A;
    assign prod_k0 = 34'(k0_sel) * 34'(t1_reg);
    assign s1_next = 35'(prod_k0) + 35'(k1_sel);
    assign d1_next = 36'(DEN_SCALE) * 36'(t1_reg);

    assign k2_sel  = sel2_reg ? COEF_K2_B : COEF_K2_A;
    assign prod_s1 = 51'(t2_reg) * 51'(s1_reg);
    assign s2_next = 52'(prod_s1) + 52'(k2_sel);
    assign d2_next = 52'(t2_reg) * 52'(d1_reg);

    assign prod_s2 = 68'(t3_reg) * 68'(s2_reg);
    assign prod_d2 = 68'(t3_reg) * 68'(d2_reg);
    assign n3_next = prod_s2[WIDE_W-1:0];
    assign d3_next = prod_d2[WIDE_W-1:0];

    assign c_sel   = sel4_reg ? COEF_C_B : COEF_C_A;
    assign n4_next = (n3_reg > 64'(c_sel)) ? (n3_reg - 64'(c_sel)) : '0;

    assign num6_next = (n4_reg >= d4_reg) ? (d4_reg - 64'd1) : n4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < STAGES; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            t1_reg   <= temperature_kelvin;
            sel1_reg <= (temperature_kelvin >= T_MID);
            st1_reg  <= st1_next;
        end
        if (adv[1])
        begin
            t2_reg   <= t1_reg;
            sel2_reg <= sel1_reg;
            st2_reg  <= st1_reg;
            s1_reg   <= s1_next;
            d1_reg   <= d1_next;
        end
        if (adv[2])
        begin
            t3_reg   <= t2_reg;
            sel3_reg <= sel2_reg;
            st3_reg  <= st2_reg;
            s2_reg   <= s2_next;
            d2_reg   <= d2_next;
        end
        if (adv[3])
        begin
            sel4_reg <= sel3_reg;
            st4_reg  <= st3_reg;
            n3_reg   <= n3_next;
            d3_reg   <= d3_next;
        end
        if (adv[4])
        begin
            st5_reg <= st4_reg;
            n4_reg  <= n4_next;
            d4_reg  <= d3_reg;
        end
        if (adv[5])
        begin
            st6_reg  <= st5_reg;
            num6_reg <= num6_next;
            den6_reg <= d4_reg;
        end
    end

    assign frac.num    = num6_reg;
    assign frac.den    = den6_reg;
    assign frac.status = st6_reg;

endmodule

// ===== hw/rtl/cctdl_div.sv =====
// restoring divider pipeline, one quotient bit per stage
module cctdl_div
    import cctdl_pkg::*;
#(
    parameter int QUOT_BITS = quot_bits(FRAC_BITS_DEF)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cctdl_frac_t          frac,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [QUOT_BITS-1:0] quotient,
    output status_t              status
);

    logic [QUOT_BITS-1:0] vld_reg;
    logic [QUOT_BITS:0]   adv;

    logic [WIDE_W-1:0]    rem_reg  [QUOT_BITS];
    logic [WIDE_W-1:0]    rem_next [QUOT_BITS];
    logic [WIDE_W-1:0]    den_reg  [QUOT_BITS];
    logic [WIDE_W-1:0]    den_next [QUOT_BITS];
    logic [QUOT_BITS-1:0] quo_reg  [QUOT_BITS];
    logic [QUOT_BITS-1:0] quo_next [QUOT_BITS];
    status_t              st_reg   [QUOT_BITS];
    status_t              st_next  [QUOT_BITS];

    assign adv[QUOT_BITS] = out_ready;

    for (genvar i = 0; i < QUOT_BITS; i++)
    begin : g_stage
        logic [WIDE_W-1:0]    src_rem;
        logic [WIDE_W-1:0]    src_den;
        logic [QUOT_BITS-1:0] src_quo;
        status_t              src_st;
        logic [WIDE_W:0]      dbl;
        logic [WIDE_W:0]      sub;
        logic                 take;

        if (i == 0)
        begin : g_head
            assign src_rem = frac.num;
            assign src_den = frac.den;
            assign src_quo = '0;
            assign src_st  = frac.status;
        end
        else
        begin : g_body
            assign src_rem = rem_reg[i-1];
            assign src_den = den_reg[i-1];
            assign src_quo = quo_reg[i-1];
            assign src_st  = st_reg[i-1];
        end

        assign dbl  = {src_rem, 1'b0};
        assign sub  = dbl - {1'b0, src_den};
        assign take = (dbl >= {1'b0, src_den});

        assign rem_next[i] = take ? sub[WIDE_W-1:0] : dbl[WIDE_W-1:0];
        assign quo_next[i] = {src_quo[QUOT_BITS-2:0], take};
        assign den_next[i] = src_den;
        assign st_next[i]  = src_st;

        assign adv[i] = !vld_reg[i] || adv[i+1];
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[QUOT_BITS-1];
    assign quotient  = quo_reg[QUOT_BITS-1];
    assign status    = st_reg[QUOT_BITS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < QUOT_BITS; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUOT_BITS; i++)
        begin
            if (adv[i])
            begin
                rem_reg[i] <= rem_next[i];
                den_reg[i] <= den_next[i];
                quo_reg[i] <= quo_next[i];
                st_reg[i]  <= st_next[i];
            end
        end
    end

endmodule

// ===== hw/rtl/cctdl_post.sv =====
// rounding of x and eight-stage pipeline for y = -3x^2 + 2.87x - 0.275
module cctdl_post
    import cctdl_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int QUOT_BITS = quot_bits(FRAC_BITS_DEF)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [QUOT_BITS-1:0] quotient,
    input  status_t              in_status,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CHROMA_W-1:0]  x_chroma,
    output logic [CHROMA_W-1:0]  y_chroma,
    output status_t              status
);

    localparam int STAGES  = 8;
    localparam int X28_W   = X_WORK_BITS + 1;
    localparam int DIFF_W  = 38;
    localparam int SPLIT   = 19;
    localparam int PART_W  = X28_W + SPLIT;
    localparam int Y_SHIFT = Y_OFF_EXP - FRAC_BITS;
    localparam int V_W     = WIDE_W - Y_SHIFT;
    localparam int U_LSB   = 3;
    localparam int U_W     = 21;
    localparam int M_W     = U_W + 22;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES:0]   adv;

    status_t st1_reg, st2_reg, st3_reg, st4_reg, st5_reg, st6_reg, st7_reg, st8_reg;
    logic [CHROMA_W-1:0] x1_reg, x2_reg, x3_reg, x4_reg, x5_reg, x6_reg, x7_reg, x8_reg;
    logic [CHROMA_W-1:0] x1_next, x8_next, y8_reg, y8_next;

    logic [X28_W-1:0]  x28_1_reg, x28_1_next, x28_2_reg;
    logic [DIFF_W-1:0] diff2_reg, diff2_next;
    logic              ge2_reg, ge2_next, ge3_reg, ge4_reg;
    logic [PART_W-1:0] pl3_reg, pl3_next, ph3_reg, ph3_next;
    logic [WIDE_W-1:0] prod4_reg, prod4_next;
    logic [V_W-1:0]    v5_reg, v5_next;
    logic              yz5_reg, yz5_next, yz6_reg, yz7_reg;
    logic [U_W-1:0]    u6_reg, u6_next;
    logic              sat6_reg, sat6_next, sat7_reg;
    logic [M_W-1:0]    m7_reg, m7_next;

    logic [FRAC_BITS:0]   xq;
    logic [FRAC_BITS+1:0] xsum;
    logic [FRAC_BITS:0]   xrnd;
    logic                 xsat;
    logic [X28_W-1:0]     xw;
    logic [X28_W:0]       xwsum;
    logic [DIFF_W-1:0]    t300;
    logic [WIDE_W-1:0]    dv;
    logic [WIDE_W-1:0]    w6;

    assign adv[STAGES] = out_ready;
    for (genvar i = 0; i < STAGES; i++)
    begin : g_adv
        assign adv[i] = !vld_reg[i] || adv[i+1];
    end
    assign in_ready  = adv[0];
    assign out_valid = vld_reg[STAGES-1];

    // round x to the field width and to the working width from one quotient
    assign xq         = quotient[QUOT_BITS-1 -: FRAC_BITS+1];
    assign xsum       = {1'b0, xq} + (FRAC_BITS+2)'(1);
    assign xrnd       = xsum[FRAC_BITS+1:1];
    assign xsat       = (64'(xrnd) > 64'(CHROMA_MAX));
    assign x1_next    = xsat ? CHROMA_MAX : CHROMA_W'(xrnd);
    assign xw         = quotient[QUOT_BITS-1 -: X28_W];
    assign xwsum      = {1'b0, xw} + (X28_W+1)'(1);
    assign x28_1_next = xwsum[X28_W:1];

    assign t300       = DIFF_W'(Y_X_MUL) * DIFF_W'(x28_1_reg);
    assign ge2_next   = (t300 >= Y_LIN);
    assign diff2_next = Y_LIN - t300;

    assign pl3_next = PART_W'(x28_2_reg) * PART_W'(diff2_reg[SPLIT-1:0]);
    assign ph3_next = PART_W'(x28_2_reg) * PART_W'(diff2_reg[DIFF_W-1:SPLIT]);

    assign prod4_next = 64'(pl3_reg) + 64'({ph3_reg, {SPLIT{1'b0}}});

    assign yz5_next = ge4_reg || (prod4_reg <= Y_OFF);
    assign dv       = prod4_reg - Y_OFF;
    assign v5_next  = dv[WIDE_W-1:Y_SHIFT];

    // divide by 200: shift right by 3 (divide by 8), then reciprocal multiply by 1/25
    assign w6        = 64'(v5_reg) + Y_BIAS;
    assign sat6_next = (w6 >= Y_SAT_LIMIT);
    assign u6_next   = w6[U_LSB+U_W-1:U_LSB];

    assign m7_next = M_W'(u6_reg) * M_W'(Y_RECIP);

    always_comb
    begin
        if (st7_reg != STATUS_OK)
        begin
            x8_next = '0;
            y8_next = '0;
        end
        else
        begin
            x8_next = x7_reg;
            priority if (yz7_reg)
            begin
                y8_next = '0;
            end
            else if (sat7_reg)
            begin
                y8_next = CHROMA_MAX;
            end
            else
            begin
                y8_next = m7_reg[Y_RECIP_SHIFT +: CHROMA_W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < STAGES; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            st1_reg   <= in_status;
            x1_reg    <= x1_next;
            x28_1_reg <= x28_1_next;
        end
        if (adv[1])
        begin
            st2_reg   <= st1_reg;
            x2_reg    <= x1_reg;
            x28_2_reg <= x28_1_reg;
            ge2_reg   <= ge2_next;
            diff2_reg <= diff2_next;
        end
        if (adv[2])
        begin
            st3_reg <= st2_reg;
            x3_reg  <= x2_reg;
            ge3_reg <= ge2_reg;
            pl3_reg <= pl3_next;
            ph3_reg <= ph3_next;
        end
        if (adv[3])
        begin
            st4_reg   <= st3_reg;
            x4_reg    <= x3_reg;
            ge4_reg   <= ge3_reg;
            prod4_reg <= prod4_next;
        end
        if (adv[4])
        begin
            st5_reg <= st4_reg;
            x5_reg  <= x4_reg;
            yz5_reg <= yz5_next;
            v5_reg  <= v5_next;
        end
        if (adv[5])
        begin
            st6_reg  <= st5_reg;
            x6_reg   <= x5_reg;
            yz6_reg  <= yz5_reg;
            sat6_reg <= sat6_next;
            u6_reg   <= u6_next;
        end
        if (adv[6])
        begin
            st7_reg  <= st6_reg;
            x7_reg   <= x6_reg;
            yz7_reg  <= yz6_reg;
            sat7_reg <= sat6_reg;
            m7_reg   <= m7_next;
        end
        if (adv[7])
        begin
            st8_reg <= st7_reg;
            x8_reg  <= x8_next;
            y8_reg  <= y8_next;
        end
    end

    assign x_chroma = x8_reg;
    assign y_chroma = y8_reg;
    assign status   = st8_reg;

endmodule

// ===== hw/rtl/cct_to_daylight_chromaticity_unit.sv =====
// top level: daylight-locus x and y chromaticity from a temperature in kelvin
// stages: 6 polynomial stages, one divider stage per quotient bit, 8 rounding and y stages
// throughput: one word per cycle; each stage holds under backpressure and fills bubbles
// reset: rst_n clears every stage valid bit asynchronously; data registers are not reset
module cct_to_daylight_chromaticity_unit
    import cctdl_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [TEMP_W-1:0]   temperature_kelvin,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CHROMA_W-1:0] x_chroma,
    output logic [CHROMA_W-1:0] y_chroma,
    output logic [1:0]          status
);

    localparam int QUOT_BITS = quot_bits(FRAC_BITS);

    cctdl_frac_t          frac;
    logic                 poly_valid;
    logic                 poly_ready;
    logic                 div_valid;
    logic                 div_ready;
    logic [QUOT_BITS-1:0] quotient;
    status_t              div_status;
    status_t              post_status;

    cctdl_poly u_poly (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .temperature_kelvin (temperature_kelvin),
        .out_valid          (poly_valid),
        .out_ready          (poly_ready),
        .frac               (frac)
    );

    cctdl_div #(
        .QUOT_BITS (QUOT_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (poly_valid),
        .in_ready  (poly_ready),
        .frac      (frac),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .quotient  (quotient),
        .status    (div_status)
    );

    cctdl_post #(
        .FRAC_BITS (FRAC_BITS),
        .QUOT_BITS (QUOT_BITS)
    ) u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .quotient  (quotient),
        .in_status (div_status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .x_chroma  (x_chroma),
        .y_chroma  (y_chroma),
        .status    (post_status)
    );

    assign status = post_status;

endmodule

// ===== hw/rtl/cctdl_checker.sv =====
// port-level assertions for the chromaticity unit and their bind
module cctdl_checker
    import cctdl_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic [TEMP_W-1:0]   temperature_kelvin,
    input logic                out_valid,
    input logic                out_ready,
    input logic [CHROMA_W-1:0] x_chroma,
    input logic [CHROMA_W-1:0] y_chroma,
    input logic [1:0]          status
);

    // flagged words carry zero chromaticity
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STATUS_OK) |-> (x_chroma == '0) && (y_chroma == '0))
        else $error("flagged word with nonzero chromaticity");

    // a valid temperature always gives a nonzero x
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_OK) |-> (x_chroma != '0))
        else $error("zero x on an in-range temperature");

    // a free output or an empty pipe never blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ready || !out_valid) |-> in_ready)
        else $error("input stalled while the pipeline can move");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(x_chroma) && $stable(y_chroma)
            && $stable(status))
        else $error("output word changed under stall");

endmodule

bind cct_to_daylight_chromaticity_unit cctdl_checker u_checker (.*);

// ===== tb/cct_to_daylight_chromaticity_checker.sv =====
// checker: predicts daylight-locus chromaticity per temperature and compares the unit's results
module cct_to_daylight_chromaticity_checker
    import cctdl_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [TEMP_W-1:0]   temperature_kelvin,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [CHROMA_W-1:0] x_chroma,
    input  logic [CHROMA_W-1:0] y_chroma,
    input  logic [1:0]          status,
    output int                  fail_count,
    output int                  pending,
    output int                  checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] LOCUS_LOW_K  = 64'd4000;
    localparam logic [63:0] LOCUS_MID_K  = 64'd7000;
    localparam logic [63:0] LOCUS_HIGH_K = 64'd25000;
    localparam logic [63:0] WARM_C  = 64'd4607000000000000;
    localparam logic [63:0] WARM_K2 = 64'd2967800000000;
    localparam logic [63:0] WARM_K1 = 64'd99110000;
    localparam logic [63:0] WARM_K0 = 64'd244063;
    localparam logic [63:0] COOL_C  = 64'd2006400000000000;
    localparam logic [63:0] COOL_K2 = 64'd1901800000000;
    localparam logic [63:0] COOL_K1 = 64'd247480000;
    localparam logic [63:0] COOL_K0 = 64'd237040;
    localparam int          X_FINE_BITS = 28;
    localparam logic [63:0] FIELD_TOP = 64'd65535;

    typedef struct packed {
        logic [TEMP_W-1:0]   temp;
        logic [CHROMA_W-1:0] x;
        logic [CHROMA_W-1:0] y;
        status_t             st;
    } chroma_word_t;

    chroma_word_t expected_chroma[$];
    int n_fail = 0;
    int n_pending = 0;
    int n_checked = 0;

    assign fail_count = n_fail;
    assign pending    = n_pending;
    assign checked    = n_checked;

    // round(n/d * 2^bits), ties up, for n < d
    function automatic logic [63:0] scaled_quotient(input logic [63:0] n, input logic [63:0] d,
                                                    input int bits);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = n;
        for (int i = 0; i < bits; i++)
        begin
            q = q << 1;
            if (r >= d - r)
            begin
                r = r - (d - r);
                q = q | 64'd1;
            end
            else
            begin
                r = r + r;
            end
        end
        if (r >= d - r)
            q = q + 64'd1;
        return q;
    endfunction

    function automatic logic [CHROMA_W-1:0] clip_field(input logic [63:0] v);
        return (v > FIELD_TOP) ? CHROMA_W'(FIELD_TOP) : CHROMA_W'(v);
    endfunction

    function automatic chroma_word_t daylight_chroma(input logic [TEMP_W-1:0] t);
        chroma_word_t res;
        logic [63:0] tt, c, k2, k1, k0, num, den, x28, lin, off, prod, v;
        res = '0;
        res.temp = t;
        tt = {48'd0, t};
        if (tt < LOCUS_LOW_K)
        begin
            res.st = STATUS_LOW;
            return res;
        end
        if (tt >= LOCUS_HIGH_K)
        begin
            res.st = STATUS_HIGH;
            return res;
        end
        if (tt < LOCUS_MID_K)
        begin
            c = WARM_C; k2 = WARM_K2; k1 = WARM_K1; k0 = WARM_K0;
        end
        else
        begin
            c = COOL_C; k2 = COOL_K2; k1 = COOL_K1; k0 = COOL_K0;
        end
        num = k2 * tt + k1 * tt * tt + k0 * tt * tt * tt;
        num = (num > c) ? num - c : 64'd0;
        den = 64'd1000000 * tt * tt * tt;
        if (num >= den)
            num = den - 64'd1;
        res.st = STATUS_OK;
        res.x  = clip_field(scaled_quotient(num, den, FRAC_BITS));
        // y from x at 28 fraction bits, scaled by 100 * 2^56
        x28 = scaled_quotient(num, den, X_FINE_BITS);
        lin = 64'd287 << X_FINE_BITS;
        off = 64'd55 << 55;
        if (64'd300 * x28 >= lin)
        begin
            res.y = '0;
        end
        else
        begin
            prod = x28 * (lin - 64'd300 * x28);
            if (prod <= off)
            begin
                res.y = '0;
            end
            else
            begin
                v = (prod - off) >> (55 - FRAC_BITS);
                res.y = clip_field((v + 64'd100) / 64'd200);
            end
        end
        return res;
    endfunction

    task automatic log_failure(input string what);
        n_fail++;
        if (n_fail <= 10)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    always @(posedge clk)
    begin : monitor
        chroma_word_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_chroma.push_back(daylight_chroma(temperature_kelvin));
            if (out_valid && out_ready)
            begin
                n_checked++;
                if (expected_chroma.size() == 0)
                begin
                    log_failure($sformatf("unexpected word x=%0d y=%0d status=%0d",
                                          x_chroma, y_chroma, status));
                end
                else
                begin
                    want = expected_chroma.pop_front();
                    if (x_chroma !== want.x || y_chroma !== want.y || status !== want.st)
                        log_failure($sformatf(
                            "T=%0d expected x=%0d y=%0d status=%0d, got x=%0d y=%0d status=%0d",
                            want.temp, want.x, want.y, want.st, x_chroma, y_chroma, status));
                end
            end
            n_pending <= expected_chroma.size();
        end
    end

endmodule

// ===== tb/cct_to_daylight_chromaticity_unit_test.sv =====
// testbench top: temperature stimulus, output stalls and verdict for the chromaticity unit
module cct_to_daylight_chromaticity_unit_test;
    import cctdl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 60;
    localparam logic [TEMP_W-1:0] CORNER_K [22] = '{
        16'd0, 16'd1, 16'd2000, 16'd3999, 16'd4000, 16'd4001, 16'd5000, 16'd6500,
        16'd6999, 16'd7000, 16'd7001, 16'd10000, 16'd15000, 16'd20000, 16'd21845,
        16'd24999, 16'd25000, 16'd25001, 16'd32768, 16'd43690, 16'd65534, 16'd65535
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [TEMP_W-1:0]   temperature_kelvin = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [CHROMA_W-1:0] x_chroma;
    logic [CHROMA_W-1:0] y_chroma;
    logic [1:0]          status;
    int                  fail_count;
    int                  pending;
    int                  checked;

    int burst_left = 0;
    int hold_requests = 0;
    int n_low = 0;
    int n_locus = 0;
    int n_high = 0;

    cct_to_daylight_chromaticity_unit DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .temperature_kelvin (temperature_kelvin),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .x_chroma           (x_chroma),
        .y_chroma           (y_chroma),
        .status             (status)
    );

    cct_to_daylight_chromaticity_checker checker_i (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #10ms;
        $display("status: fail");
        $finish;
    end

    function automatic logic [TEMP_W-1:0] random_temperature();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 2)
            return TEMP_W'($urandom_range(0, 3999));
        if (pick < 4)
            return TEMP_W'($urandom_range(25000, 65535));
        if (pick == 4)
            return TEMP_W'($urandom_range(0, 65535));
        if (pick < 12)
            return TEMP_W'($urandom_range(4000, 6999));
        return TEMP_W'($urandom_range(7000, 24999));
    endfunction

    // offer one word in bursts with random gaps; returns on the falling edge after acceptance
    task automatic send_temperature(input logic [TEMP_W-1:0] t);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        temperature_kelvin <= t;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        if (t < 16'd4000)
            n_low++;
        else if (t >= 16'd25000)
            n_high++;
        else
            n_locus++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
        burst_left = 0;
    endtask

    initial
    begin : receiver
        int mode;
        int span;
        int served;
        served = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(40, 200);
            repeat (span)
            begin
                @(negedge clk);
                if (hold_requests != served)
                begin
                    served++;
                    out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                end
                unique case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 1) == 0);
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (CORNER_K[i])
            send_temperature(CORNER_K[i]);
        drain_results();

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // long output stall while words keep coming, later a full drain
            if (n == 600)
                hold_requests++;
            if (n == 1300)
                drain_results();
            send_temperature(random_temperature());
        end

        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d temperatures: %0d in range, %0d below 4000 K, %0d from 25000 K up",
                 n_low + n_locus + n_high, n_locus, n_low, n_high);
        $display("checked %0d results through random stalls, one long output hold and two drains",
                 checked);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/cctdl_pkg.sv
hw/rtl/cctdl_poly.sv
hw/rtl/cctdl_div.sv
hw/rtl/cctdl_post.sv
hw/rtl/cct_to_daylight_chromaticity_unit.sv
hw/rtl/cctdl_checker.sv
tb/cct_to_daylight_chromaticity_checker.sv
tb/cct_to_daylight_chromaticity_unit_test.sv
